// File: src/square_rotation_classifier_unit_macros.svh
`ifndef SQUARE_ROTATION_CLASSIFIER_UNIT_MACROS_SVH
`define SQUARE_ROTATION_CLASSIFIER_UNIT_MACROS_SVH

// check a property outside reset
`define SRCU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every edge, reset included
`define SRCU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/srcu_pkg.sv
package srcu_pkg;

  localparam int MODE_W = 2;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int ELEM_W = 8;
  localparam int CODE_W = 3;
  localparam int SIZE_W = 5;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_SRC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TGT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL = 2'd2;

  localparam logic [CODE_W-1:0] CODE_SAME = 3'd0;
  localparam logic [CODE_W-1:0] CODE_CW   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_CCW  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_R180 = 3'd3;
  localparam logic [CODE_W-1:0] CODE_NONE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CCW  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_R180 = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd3;
  localparam logic [1:0]        ADDR_SIZE  = 2'd0;

  typedef struct packed {
    logic load;
    logic start;
    logic next_kind;
    logic issue;
    logic set_code;
    logic code_none;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic              mismatch;
    logic              cmp_last;
    logic              issued_all;
    logic [KIND_W-1:0] kind;
    logic              out_free;
  } sts_t;

endpackage

// File: src/srcu_chan_if.sv
interface srcu_in_if;
  import srcu_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ELEM_W-1:0] element;

  modport source (output valid, mode, row, col, element, input ready);
  modport sink (input valid, mode, row, col, element, output ready);
endinterface

interface srcu_out_if;
  import srcu_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] match_code;

  modport source (output valid, match_code, input ready);
  modport sink (input valid, match_code, output ready);
endinterface

// File: src/srcu_ctrl.sv
module srcu_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [srcu_pkg::MODE_W-1:0] in_mode,
  input  srcu_pkg::sts_t            sts,
  output logic                      in_ready,
  output logic                      busy,
  output srcu_pkg::ctl_t            ctl
);
  import srcu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        ctl.load = accept;
        if (accept && in_mode == MODE_EVAL) begin
          ctl.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.mismatch) begin
          if (sts.kind == KIND_R180) begin
            ctl.set_code  = 1'b1;
            ctl.code_none = 1'b1;
            state_next    = ST_POST;
          end else begin
            ctl.next_kind = 1'b1;
          end
        end else if (sts.cmp_last) begin
          ctl.set_code = 1'b1;
          state_next   = ST_POST;
        end else if (!sts.issued_all) begin
          ctl.issue = 1'b1;
        end
      end
      ST_POST: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/srcu_datapath.sv
module srcu_datapath #(
  parameter int MAX_DIM = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  srcu_pkg::ctl_t              ctl,
  input  logic [srcu_pkg::SIZE_W-1:0] matrix_size,
  input  logic [srcu_pkg::MODE_W-1:0] in_mode,
  input  logic [srcu_pkg::ROW_W-1:0]  in_row,
  input  logic [srcu_pkg::COL_W-1:0]  in_col,
  input  logic [srcu_pkg::ELEM_W-1:0] in_element,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [srcu_pkg::CODE_W-1:0] match_code,
  output srcu_pkg::sts_t              sts
);
  import srcu_pkg::*;

  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int XW    = (CW > ROW_W) ? CW : ROW_W;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  logic [ELEM_W-1:0] src_mem [DEPTH];
  logic [ELEM_W-1:0] tgt_mem [DEPTH];

  logic [XW-1:0]     row_x;
  logic [XW-1:0]     col_x;
  logic [AW-1:0]     wr_addr;
  logic              wr_in_range;
  logic              src_we;
  logic              tgt_we;

  logic [31:0]       side_w;
  logic [31:0]       side_m1_w;
  logic [CW-1:0]     side_m1;
  logic [CW-1:0]     r;
  logic [CW-1:0]     c;
  logic [CW-1:0]     sr;
  logic [CW-1:0]     sc;
  logic [KIND_W-1:0] kind;
  logic              issued_all;
  logic              at_last;
  logic [AW-1:0]     tgt_addr;
  logic [AW-1:0]     src_addr;
  logic [ELEM_W-1:0] tgt_q;
  logic [ELEM_W-1:0] src_q;
  logic              cmp_valid;
  logic              cmp_last;
  logic [CODE_W-1:0] code;

  assign row_x       = XW'(in_row);
  assign col_x       = XW'(in_col);
  assign wr_addr     = {row_x[CW-1:0], col_x[CW-1:0]};
  assign wr_in_range = (32'(in_row) < 32'(MAX_DIM)) && (32'(in_col) < 32'(MAX_DIM));
  assign src_we      = ctl.load && wr_in_range && (in_mode == MODE_SRC);
  assign tgt_we      = ctl.load && wr_in_range && (in_mode == MODE_TGT);

  always_comb begin
    if (matrix_size == '0) begin
      side_w = 32'd1;
    end else if (32'(matrix_size) > 32'(MAX_DIM)) begin
      side_w = 32'(MAX_DIM);
    end else begin
      side_w = 32'(matrix_size);
    end
    side_m1_w = side_w - 32'd1;
  end

  always_comb begin
    case (kind)
      KIND_SAME: begin
        sr = r;
        sc = c;
      end
      KIND_CW: begin
        sr = side_m1 - c;
        sc = r;
      end
      KIND_CCW: begin
        sr = c;
        sc = side_m1 - r;
      end
      default: begin
        sr = side_m1 - r;
        sc = side_m1 - c;
      end
    endcase
  end

  assign at_last  = (r == side_m1) && (c == side_m1);
  assign tgt_addr = {r, c};
  assign src_addr = {sr, sc};

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[wr_addr] <= in_element;
    end
    src_q <= src_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[wr_addr] <= in_element;
    end
    tgt_q <= tgt_mem[tgt_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      side_m1 <= side_m1_w[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r          <= '0;
      c          <= '0;
      kind       <= KIND_SAME;
      issued_all <= 1'b0;
      cmp_valid  <= 1'b0;
      cmp_last   <= 1'b0;
    end else begin
      cmp_valid <= ctl.issue;
      cmp_last  <= ctl.issue && at_last;
      if (ctl.start || ctl.next_kind) begin
        r          <= '0;
        c          <= '0;
        issued_all <= 1'b0;
        kind       <= ctl.start ? KIND_SAME : kind + 2'd1;
      end else if (ctl.issue) begin
        if (at_last) begin
          issued_all <= 1'b1;
        end
        if (c == side_m1) begin
          c <= '0;
          r <= r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.set_code) begin
      code <= ctl.code_none ? CODE_NONE : CODE_W'(kind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      match_code <= code;
    end
  end

  always_comb begin
    sts            = '0;
    sts.mismatch   = cmp_valid && (tgt_q != src_q);
    sts.cmp_last   = cmp_valid && cmp_last;
    sts.issued_all = issued_all;
    sts.kind       = kind;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// File: src/square_rotation_classifier_unit.sv
// Load words (source or target element writes) are accepted back to back while idle.
// An evaluate word compares the orientations of side S in turn: one element pair per
// cycle is read from the two element memories while an orientation is scanned,
// each orientation stops at its first mismatch, and the input stalls until the
// code is in the output register. Reset clears control, the output valid and
// sets matrix_size to 3; element memories are not cleared.
`include "square_rotation_classifier_unit_macros.svh"

module square_rotation_classifier_unit #(
  parameter int MAX_DIM = 16
) (
  input  logic                clk,
  input  logic                rst,
  srcu_in_if.sink             items,
  srcu_out_if.source          results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import srcu_pkg::*;

  logic [SIZE_W-1:0] matrix_size;
  logic              in_ready;
  logic              busy;
  ctl_t              ctl;
  sts_t              sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SIZE) ? 32'(matrix_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SIZE) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign items.ready = in_ready;

  srcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_mode  (items.mode),
    .sts      (sts),
    .in_ready (in_ready),
    .busy     (busy),
    .ctl      (ctl)
  );

  srcu_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .matrix_size (matrix_size),
    .in_mode     (items.mode),
    .in_row      (items.row),
    .in_col      (items.col),
    .in_element  (items.element),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .match_code  (results.match_code),
    .sts         (sts)
  );

  `SRCU_ASSERT(a_code_range, results.valid |-> (results.match_code <= CODE_NONE), "match code out of range")
  `SRCU_ASSERT(a_eval_stalls, (items.valid && items.ready && items.mode == MODE_EVAL) |=> (busy && !items.ready), "evaluate did not stall input")
  `SRCU_ASSERT(a_emit_free, ctl.emit |-> sts.out_free, "result overwrote a waiting result")
  `SRCU_ASSERT_ALWAYS(a_reset_idle, rst |=> (!results.valid && items.ready), "block not idle after reset")

endmodule
